@@ src/crsf_mavlink_frame_validator_unit_macros.svh @@
// Assertion macros used by the frame validator top level.
`ifndef CRSF_MAVLINK_FRAME_VALIDATOR_UNIT_MACROS_SVH
`define CRSF_MAVLINK_FRAME_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define CMFV_ASSERT_NOW(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define CMFV_ASSERT_NEXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ src/cmfv_pkg.sv @@
// Shared types, constants and CRC functions of the CRSF and MAVLink frame validator.
`default_nettype none

package cmfv_pkg;

    localparam int unsigned CRSF_MAX_LEN = 62;
    localparam int unsigned CRSF_MIN_LEN = 2;

    localparam logic [7:0]  CRSF_SYNC_FC    = 8'hC8;
    localparam logic [7:0]  CRSF_SYNC_RX    = 8'hEE;
    localparam logic [7:0]  CRSF_SYNC_TX    = 8'hEA;
    localparam logic [7:0]  CRC8_POLY       = 8'hD5;

    localparam logic [7:0]  MAV_STX_V1      = 8'hFE;
    localparam logic [7:0]  MAV_STX_V2      = 8'hFD;
    localparam logic [15:0] X25_INIT        = 16'hFFFF;
    localparam logic [8:0]  MAV_OVERHEAD_V1 = 9'd8;
    localparam logic [8:0]  MAV_OVERHEAD_V2 = 9'd12;
    localparam logic [8:0]  MAV_V1_ID_POS   = 9'd5;
    localparam logic [8:0]  MAV_V2_ID_POS0  = 9'd7;
    localparam logic [8:0]  MAV_V2_ID_POS1  = 9'd8;
    localparam logic [8:0]  MAV_V2_ID_POS2  = 9'd9;

    localparam logic [23:0] EXTRA_MSG_ID_RST = 24'd33;
    localparam logic [7:0]  EXTRA_CRC_RST    = 8'd104;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_MSG_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_CRC    = 1'd1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef struct packed {
        logic        good;
        logic [6:0]  frame_len;
    } crsf_res_t;

    typedef struct packed {
        logic        good;
        logic [8:0]  frame_len;
        logic        version_two;
    } mav_res_t;

    typedef struct packed {
        logic [23:0] extra_msg_id;
        logic [7:0]  extra_crc_value;
    } mav_cfg_t;

    // One byte of CRC-8 with polynomial 0xD5, MSB first.
    function automatic logic [7:0] crc8_d5_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC8_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // One byte of the X.25 CRC used by MAVLink.
    function automatic logic [15:0] x25_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

`default_nettype wire

@@ src/cmfv_ifs.sv @@
// Valid/ready channel interfaces for the byte stream and the validation results.
`default_nettype none

interface cmfv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cmfv_result_if;
    logic       valid;
    logic       ready;
    logic       crsf_good;
    logic [6:0] crsf_frame_len;
    logic       mav_good;
    logic [8:0] mav_frame_len;
    logic       mav_version_two;

    modport source (output valid, output crsf_good, output crsf_frame_len,
                    output mav_good, output mav_frame_len, output mav_version_two,
                    input ready);
    modport sink   (input valid, input crsf_good, input crsf_frame_len,
                    input mav_good, input mav_frame_len, input mav_version_two,
                    output ready);
endinterface

`default_nettype wire

@@ src/crsf_mavlink_frame_validator_unit.sv @@
// Top level of the CRSF and MAVLink frame validator.
// The unit takes one byte of a mixed serial stream per request on the bytes
// channel and returns exactly one request on the results channel for every
// byte, in order. A CRSF parser and a MAVLink parser look at each byte side
// by side; a result flags a CRSF frame (sync, length 2 to 62, type, payload,
// CRC-8 poly 0xD5) or a MAVLink v1/v2 frame (X.25 CRC with CRC-extra) whose
// last byte is this one, and gives its total length. The sustained rate is
// one byte per clock cycle while results are taken: each parser updates its
// CRC incrementally, so one byte-wide CRC step plus the frame-end compare is
// all the logic between the input register and the result register. An
// accepted byte waits in the input register and moves into the result
// register when that register is free, and its result is offered from there.
// The input register and the result register form a two-entry pipeline, so a
// byte is still taken while a finished result waits; bytes.ready drops only
// when both hold an item and results.ready is low. The configuration
// registers (message id that gets the CRC-extra byte, and that byte) must be
// written through cfg_we, cfg_index and cfg_data only while no byte is in
// flight; the block itself does not enforce this. They reset to 33 and 104.
`default_nettype none
`include "crsf_mavlink_frame_validator_unit_macros.svh"

module crsf_mavlink_frame_validator_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    cmfv_byte_if.sink                                bytes,
    cmfv_result_if.source                            results,
    input  wire logic                                cfg_we,
    input  wire logic [cmfv_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cmfv_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Input register stage.
    logic       s1_vld_reg, s1_vld_next;
    logic [7:0] s1_byte_reg;

    // Result register stage.
    logic                 out_vld_reg, out_vld_next;
    cmfv_pkg::crsf_res_t  crsf_out_reg;
    cmfv_pkg::mav_res_t   mav_out_reg;

    // Configuration registers.
    logic [23:0] extra_msg_id_reg;
    logic [7:0]  extra_crc_value_reg;

    cmfv_pkg::mav_cfg_t   mav_cfg;
    cmfv_pkg::crsf_res_t  crsf_res;
    cmfv_pkg::mav_res_t   mav_res;

    logic in_accept;
    logic out_free;
    logic s1_adv;

    // The result register frees up when it is empty or being drained; the
    // parsers step exactly when a byte moves from the input register into it.
    assign out_free    = !out_vld_reg || results.ready;
    assign s1_adv      = s1_vld_reg && out_free;
    assign bytes.ready = !s1_vld_reg || s1_adv;
    assign in_accept   = bytes.valid && bytes.ready;

    assign s1_vld_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_reg);
    assign out_vld_next = s1_adv ? 1'b1 : (results.ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_byte_reg <= bytes.in_byte;
        if (s1_adv)
        begin
            crsf_out_reg <= crsf_res;
            mav_out_reg  <= mav_res;
        end
    end

    // Configuration writes; an index outside the register list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_msg_id_reg    <= cmfv_pkg::EXTRA_MSG_ID_RST;
            extra_crc_value_reg <= cmfv_pkg::EXTRA_CRC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cmfv_pkg::CFG_EXTRA_MSG_ID: extra_msg_id_reg    <= cfg_data[23:0];
                cmfv_pkg::CFG_EXTRA_CRC:    extra_crc_value_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign mav_cfg = {extra_msg_id_reg, extra_crc_value_reg};

    cmfv_crsf_parser u_crsf (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_adv),
        .byte_in (s1_byte_reg),
        .res     (crsf_res)
    );

    cmfv_mav_parser u_mav (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (s1_adv),
        .byte_in (s1_byte_reg),
        .cfg     (mav_cfg),
        .res     (mav_res)
    );

    assign results.valid           = out_vld_reg;
    assign results.crsf_good       = crsf_out_reg.good;
    assign results.crsf_frame_len  = crsf_out_reg.frame_len;
    assign results.mav_good        = mav_out_reg.good;
    assign results.mav_frame_len   = mav_out_reg.frame_len;
    assign results.mav_version_two = mav_out_reg.version_two;

    // A good CRSF frame is between 4 and 64 bytes; no good frame means length zero.
    `CMFV_ASSERT_NOW(a_crsf_len, out_vld_reg, (crsf_out_reg.good ? (crsf_out_reg.frame_len >= 7'd4 && crsf_out_reg.frame_len <= 7'd64) : (crsf_out_reg.frame_len == 7'd0)), "CRSF result length inconsistent with good flag")

    // A good MAVLink frame is at least a bare header; v2 needs the longer header.
    `CMFV_ASSERT_NOW(a_mav_len, out_vld_reg && mav_out_reg.good, (mav_out_reg.frame_len >= 9'd8 && (!mav_out_reg.version_two || mav_out_reg.frame_len >= 9'd12)), "MAVLink result length below header size")

    // Without a good MAVLink frame the length and version fields stay clear.
    `CMFV_ASSERT_NOW(a_mav_idle, out_vld_reg && !mav_out_reg.good, (mav_out_reg.frame_len == 9'd0 && !mav_out_reg.version_two), "MAVLink fields set without a good frame")

    // A byte that cannot move on stays in the input register.
    `CMFV_ASSERT_NEXT(a_s1_hold, s1_vld_reg && !out_free, s1_vld_reg, "input stage lost a byte while stalled")

endmodule

`default_nettype wire

@@ src/cmfv_crsf_parser.sv @@
// CRSF frame parser: sync, length, body and CRC-8 check, one byte per step.
`default_nettype none

module cmfv_crsf_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          byte_in,
    output cmfv_pkg::crsf_res_t      res
);

    cmfv_pkg::phase_t phase_reg, phase_next;
    logic [6:0]       count_reg, count_next;
    logic [5:0]       length_reg, length_next;
    logic [7:0]       crc_reg, crc_next;

    logic [6:0] total;
    logic       len_ok;
    logic       body_end;

    assign total    = {1'b0, length_reg} + 7'd2;
    assign len_ok   = (byte_in >= 8'(cmfv_pkg::CRSF_MIN_LEN)) &&
                      (byte_in <= 8'(cmfv_pkg::CRSF_MAX_LEN));
    assign body_end = (count_reg + 7'd1) >= total;

    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        crc_next    = crc_reg;
        case (phase_reg)
            cmfv_pkg::PH_LEN:
            begin
                if (len_ok)
                begin
                    length_next = byte_in[5:0];
                    count_next  = 7'd2;
                    crc_next    = 8'h00;
                    phase_next  = cmfv_pkg::PH_BODY;
                end
                else
                begin
                    phase_next = cmfv_pkg::PH_IDLE;
                end
            end
            cmfv_pkg::PH_BODY:
            begin
                count_next = count_reg + 7'd1;
                if (body_end)
                    phase_next = cmfv_pkg::PH_IDLE;
                else
                    crc_next = cmfv_pkg::crc8_d5_byte(crc_reg, byte_in);
            end
            default:
            begin
                if (byte_in inside {cmfv_pkg::CRSF_SYNC_FC, cmfv_pkg::CRSF_SYNC_RX,
                                    cmfv_pkg::CRSF_SYNC_TX})
                begin
                    count_next = 7'd1;
                    phase_next = cmfv_pkg::PH_LEN;
                end
            end
        endcase
    end

    // The byte after the last body byte is the received CRC.
    always_comb
    begin
        res.good      = (phase_reg == cmfv_pkg::PH_BODY) && body_end && (crc_reg == byte_in);
        res.frame_len = res.good ? total : 7'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cmfv_pkg::PH_IDLE;
            count_reg  <= 7'd0;
            length_reg <= 6'd0;
            crc_reg    <= 8'h00;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

`default_nettype wire

@@ src/cmfv_mav_parser.sv @@
// MAVLink v1/v2 frame parser with X.25 CRC and CRC-extra check, one byte per step.
`default_nettype none

module cmfv_mav_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [7:0]          byte_in,
    input  wire cmfv_pkg::mav_cfg_t  cfg,
    output cmfv_pkg::mav_res_t       res
);

    cmfv_pkg::phase_t phase_reg, phase_next;
    logic [8:0]       count_reg, count_next;
    logic [7:0]       length_reg, length_next;
    logic             is_two_reg, is_two_next;
    logic [15:0]      crc_reg, crc_next;
    logic [23:0]      msg_id_reg, msg_id_next;
    logic [7:0]       crc_low_reg, crc_low_next;

    logic [8:0]  total;
    logic [9:0]  pos_p2;
    logic        frame_end;
    logic [23:0] msg_id_upd;
    logic [7:0]  extra;

    assign total     = {1'b0, length_reg} +
                       (is_two_reg ? cmfv_pkg::MAV_OVERHEAD_V2 : cmfv_pkg::MAV_OVERHEAD_V1);
    assign pos_p2    = {1'b0, count_reg} + 10'd2;
    assign frame_end = ({1'b0, count_reg} + 10'd1) >= {1'b0, total};

    // Message id bytes sit at fixed header positions.
    always_comb
    begin
        msg_id_upd = msg_id_reg;
        if (is_two_reg)
        begin
            if (count_reg == cmfv_pkg::MAV_V2_ID_POS0)
                msg_id_upd = {msg_id_reg[23:8], byte_in};
            else if (count_reg == cmfv_pkg::MAV_V2_ID_POS1)
                msg_id_upd = {msg_id_reg[23:16], byte_in, msg_id_reg[7:0]};
            else if (count_reg == cmfv_pkg::MAV_V2_ID_POS2)
                msg_id_upd = {byte_in, msg_id_reg[15:0]};
        end
        else if (count_reg == cmfv_pkg::MAV_V1_ID_POS)
        begin
            msg_id_upd = {16'h0000, byte_in};
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        is_two_next  = is_two_reg;
        crc_next     = crc_reg;
        msg_id_next  = msg_id_reg;
        crc_low_next = crc_low_reg;
        case (phase_reg)
            cmfv_pkg::PH_LEN:
            begin
                length_next = byte_in;
                crc_next    = cmfv_pkg::x25_byte(crc_reg, byte_in);
                count_next  = 9'd2;
                phase_next  = cmfv_pkg::PH_BODY;
            end
            cmfv_pkg::PH_BODY:
            begin
                count_next  = count_reg + 9'd1;
                msg_id_next = msg_id_upd;
                if (pos_p2 < {1'b0, total})
                    crc_next = cmfv_pkg::x25_byte(crc_reg, byte_in);
                else if (pos_p2 == {1'b0, total})
                    crc_low_next = byte_in;
                if (frame_end)
                    phase_next = cmfv_pkg::PH_IDLE;
            end
            default:
            begin
                if (byte_in inside {cmfv_pkg::MAV_STX_V1, cmfv_pkg::MAV_STX_V2})
                begin
                    is_two_next  = (byte_in == cmfv_pkg::MAV_STX_V2);
                    crc_next     = cmfv_pkg::X25_INIT;
                    msg_id_next  = 24'd0;
                    crc_low_next = 8'h00;
                    count_next   = 9'd1;
                    phase_next   = cmfv_pkg::PH_LEN;
                end
            end
        endcase
    end

    // The last byte is the CRC high byte; the CRC-extra is folded in only here.
    always_comb
    begin
        extra           = (msg_id_upd == cfg.extra_msg_id) ? cfg.extra_crc_value : 8'h00;
        res.good        = (phase_reg == cmfv_pkg::PH_BODY) && frame_end &&
                          (cmfv_pkg::x25_byte(crc_reg, extra) == {byte_in, crc_low_reg});
        res.frame_len   = res.good ? total : 9'd0;
        res.version_two = res.good && is_two_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= cmfv_pkg::PH_IDLE;
            count_reg   <= 9'd0;
            length_reg  <= 8'd0;
            is_two_reg  <= 1'b0;
            crc_reg     <= cmfv_pkg::X25_INIT;
            msg_id_reg  <= 24'd0;
            crc_low_reg <= 8'h00;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            is_two_reg  <= is_two_next;
            crc_reg     <= crc_next;
            msg_id_reg  <= msg_id_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_crsf_mavlink_frame_validator_unit.sv @@
// Self-checking testbench for the CRSF and MAVLink frame validator unit.
module tb_crsf_mavlink_frame_validator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF_PERIOD    = 4;
    localparam int          RESET_CYCLES       = 8;
    // A byte passes through the input register and the result register before its
    // result can be taken, so this drain wait after the last expected result catches strays.
    localparam int          DRAIN_CYCLES       = 8;
    localparam int          MAX_REPORTS        = 10;
    localparam int          MAX_SEND_GAP       = 24;
    localparam int          HOLD_OFF_CYCLES    = 200;
    localparam int          RANDOM_PHASE_BYTES = 170;
    // Bit-reversed form of the CCITT polynomial, which is what the X.25 CRC
    // of MAVLink computes when it is shifted out LSB first.
    localparam logic [15:0] X25_REFLECTED_POLY = 16'h8408;

    // One result request, in the order the fields appear on the result channel.
    typedef struct packed {
        logic       crsf_good;
        logic [6:0] crsf_frame_len;
        logic       mav_good;
        logic [8:0] mav_frame_len;
        logic       mav_version_two;
    } frame_flags_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [cmfv_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cmfv_pkg::CFG_DATA_W-1:0] cfg_data;

    cmfv_byte_if   byte_ch ();
    cmfv_result_if result_ch ();

    crsf_mavlink_frame_validator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (byte_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Parser state of the predictor. Both parsers see every byte and never
    // look at each other's state.
    cmfv_pkg::phase_t crsf_phase_q;
    logic [6:0]       crsf_count_q;
    logic [5:0]       crsf_length_q;
    logic [7:0]       crsf_crc_q;
    cmfv_pkg::phase_t mav_phase_q;
    logic [8:0]       mav_count_q;
    logic [7:0]       mav_length_q;
    logic             mav_v2_q;
    logic [15:0]      mav_crc_q;
    logic [23:0]      mav_msg_id_q;
    logic [7:0]       mav_crc_lo_q;

    // Shadow copies of the two configuration registers.
    logic [23:0] cfg_extra_id;
    logic [7:0]  cfg_extra_byte;

    frame_flags_t expected_flags[$];
    logic [7:0]   frame_buf[$];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    logic         hold_rx;

    always #CLK_HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8) c = c[7] ? ((c << 1) ^ cmfv_pkg::CRC8_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [15:0] x25_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ X25_REFLECTED_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic reset_model();
        cfg_extra_id   = cmfv_pkg::EXTRA_MSG_ID_RST;
        cfg_extra_byte = cmfv_pkg::EXTRA_CRC_RST;
        crsf_phase_q   = cmfv_pkg::PH_IDLE;
        crsf_count_q   = '0;
        crsf_length_q  = '0;
        crsf_crc_q     = '0;
        mav_phase_q    = cmfv_pkg::PH_IDLE;
        mav_count_q    = '0;
        mav_length_q   = '0;
        mav_v2_q       = 1'b0;
        mav_crc_q      = cmfv_pkg::X25_INIT;
        mav_msg_id_q   = '0;
        mav_crc_lo_q   = '0;
    endtask

    // Advances both parsers by one byte and returns the flags that byte produces.
    function automatic frame_flags_t validate_byte(input logic [7:0] b);
        frame_flags_t r;
        int           crsf_total;
        int           mav_pos;
        int           mav_total;
        logic [7:0]   extra;
        r = '0;

        case (crsf_phase_q)
            cmfv_pkg::PH_LEN:
            begin
                // A length out of range drops the parser back to idle; that
                // byte is not looked at again as a possible sync byte.
                if (b >= cmfv_pkg::CRSF_MIN_LEN && b <= cmfv_pkg::CRSF_MAX_LEN)
                begin
                    crsf_length_q = b[5:0];
                    crsf_count_q  = 7'd2;
                    crsf_crc_q    = 8'h00;
                    crsf_phase_q  = cmfv_pkg::PH_BODY;
                end
                else
                begin
                    crsf_phase_q = cmfv_pkg::PH_IDLE;
                end
            end
            cmfv_pkg::PH_BODY:
            begin
                crsf_total   = crsf_length_q + 2;
                crsf_count_q = crsf_count_q + 7'd1;
                if (crsf_count_q >= crsf_total)
                begin
                    if (crsf_crc_q == b)
                    begin
                        r.crsf_good      = 1'b1;
                        r.crsf_frame_len = crsf_total[6:0];
                    end
                    crsf_phase_q = cmfv_pkg::PH_IDLE;
                end
                else
                begin
                    crsf_crc_q = crc8_step(crsf_crc_q, b);
                end
            end
            default:
            begin
                if (b == cmfv_pkg::CRSF_SYNC_FC || b == cmfv_pkg::CRSF_SYNC_RX ||
                    b == cmfv_pkg::CRSF_SYNC_TX)
                begin
                    crsf_count_q = 7'd1;
                    crsf_phase_q = cmfv_pkg::PH_LEN;
                end
            end
        endcase

        case (mav_phase_q)
            cmfv_pkg::PH_LEN:
            begin
                mav_length_q = b;
                mav_crc_q    = x25_step(mav_crc_q, b);
                mav_count_q  = 9'd2;
                mav_phase_q  = cmfv_pkg::PH_BODY;
            end
            cmfv_pkg::PH_BODY:
            begin
                mav_pos     = mav_count_q;
                mav_total   = mav_length_q + (mav_v2_q ? cmfv_pkg::MAV_OVERHEAD_V2 :
                                                         cmfv_pkg::MAV_OVERHEAD_V1);
                mav_count_q = mav_count_q + 9'd1;
                if (mav_v2_q)
                begin
                    if (mav_pos == cmfv_pkg::MAV_V2_ID_POS0)
                        mav_msg_id_q[7:0] = b;
                    else if (mav_pos == cmfv_pkg::MAV_V2_ID_POS1)
                        mav_msg_id_q[15:8] = b;
                    else if (mav_pos == cmfv_pkg::MAV_V2_ID_POS2)
                        mav_msg_id_q[23:16] = b;
                end
                else if (mav_pos == cmfv_pkg::MAV_V1_ID_POS)
                begin
                    mav_msg_id_q = {16'h0000, b};
                end
                if (mav_pos + 2 < mav_total)
                    mav_crc_q = x25_step(mav_crc_q, b);
                else if (mav_pos + 2 == mav_total)
                    mav_crc_lo_q = b;
                if (mav_count_q >= mav_total)
                begin
                    // Only the configured id folds in the extra byte; a v1 id is
                    // eight bits, so it can match only an id below 256.
                    extra = (mav_msg_id_q == cfg_extra_id) ? cfg_extra_byte : 8'h00;
                    if (x25_step(mav_crc_q, extra) == {b, mav_crc_lo_q})
                    begin
                        r.mav_good        = 1'b1;
                        r.mav_frame_len   = mav_total[8:0];
                        r.mav_version_two = mav_v2_q;
                    end
                    mav_phase_q = cmfv_pkg::PH_IDLE;
                end
            end
            default:
            begin
                if (b == cmfv_pkg::MAV_STX_V1 || b == cmfv_pkg::MAV_STX_V2)
                begin
                    mav_v2_q     = (b == cmfv_pkg::MAV_STX_V2);
                    mav_crc_q    = cmfv_pkg::X25_INIT;
                    mav_msg_id_q = '0;
                    mav_crc_lo_q = '0;
                    mav_count_q  = 9'd1;
                    mav_phase_q  = cmfv_pkg::PH_LEN;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Byte stream: sending, frame building
    // ------------------------------------------------------------------

    // Offers one byte request, with a random idle gap in front of it, and
    // records the expected flags once the unit has taken it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < MAX_SEND_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        expected_flags.push_back(validate_byte(b));
    endtask

    // Lowers valid at the edge of the last accepted request.
    task automatic stop_bytes();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_byte(frame_buf[i]);
    endtask

    // Random content byte. Most of the time it keeps clear of the other
    // protocol's sync bytes, so that the other parser does not run off and
    // swallow the frames that follow.
    function automatic logic [7:0] body_byte(input logic in_crsf);
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(0, 9) != 0)
        begin
            if (in_crsf)
            begin
                while (v == cmfv_pkg::MAV_STX_V1 || v == cmfv_pkg::MAV_STX_V2)
                    v = 8'($urandom);
            end
            else
            begin
                while (v == cmfv_pkg::CRSF_SYNC_FC || v == cmfv_pkg::CRSF_SYNC_RX ||
                       v == cmfv_pkg::CRSF_SYNC_TX)
                    v = 8'($urandom);
            end
        end
        return v;
    endfunction

    // A CRC byte that is certainly wrong, often one that looks like a sync byte
    // so that the frame end is seen not to start a new frame.
    function automatic logic [7:0] wrong_byte(input logic [7:0] good);
        logic [7:0] v;
        case ($urandom_range(0, 3))
            0:       v = cmfv_pkg::CRSF_SYNC_FC;
            1:       v = cmfv_pkg::MAV_STX_V1;
            2:       v = cmfv_pkg::MAV_STX_V2;
            default: v = good ^ (8'h01 << $urandom_range(0, 7));
        endcase
        if (v == good)
            v = ~good;
        return v;
    endfunction

    task automatic build_crsf_frame(input int len, input logic corrupt);
        int         i;
        logic [7:0] crc;
        logic [7:0] v;
        frame_buf.delete();
        case ($urandom_range(0, 2))
            0:       frame_buf.push_back(cmfv_pkg::CRSF_SYNC_FC);
            1:       frame_buf.push_back(cmfv_pkg::CRSF_SYNC_RX);
            default: frame_buf.push_back(cmfv_pkg::CRSF_SYNC_TX);
        endcase
        frame_buf.push_back(8'(len));
        crc = 8'h00;
        // Type byte and payload: length minus the CRC byte.
        for (i = 0; i < len - 1; i++)
        begin
            v   = body_byte(1'b1);
            crc = crc8_step(crc, v);
            frame_buf.push_back(v);
        end
        frame_buf.push_back(corrupt ? wrong_byte(crc) : crc);
    endtask

    task automatic build_mav_frame(input logic v2, input logic [7:0] len,
                                   input logic [23:0] msg_id, input logic corrupt);
        int          i;
        logic [15:0] crc;
        logic [23:0] seen_id;
        logic [7:0]  extra;
        frame_buf.delete();
        frame_buf.push_back(v2 ? cmfv_pkg::MAV_STX_V2 : cmfv_pkg::MAV_STX_V1);
        frame_buf.push_back(len);
        if (v2)
        begin
            // Incompat and compat flags, sequence, system and component.
            repeat (5) frame_buf.push_back(body_byte(1'b0));
            frame_buf.push_back(msg_id[7:0]);
            frame_buf.push_back(msg_id[15:8]);
            frame_buf.push_back(msg_id[23:16]);
            seen_id = msg_id;
        end
        else
        begin
            repeat (3) frame_buf.push_back(body_byte(1'b0));
            frame_buf.push_back(msg_id[7:0]);
            seen_id = {16'h0000, msg_id[7:0]};
        end
        repeat (len) frame_buf.push_back(body_byte(1'b0));
        crc = cmfv_pkg::X25_INIT;
        for (i = 1; i < frame_buf.size(); i++)
            crc = x25_step(crc, frame_buf[i]);
        extra = (seen_id == cfg_extra_id) ? cfg_extra_byte : 8'h00;
        crc   = x25_step(crc, extra);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(corrupt ? wrong_byte(crc[15:8]) : crc[15:8]);
    endtask

    // Half of the frames carry the configured id, the rest a random one.
    function automatic logic [23:0] pick_msg_id();
        return ($urandom_range(0, 1) == 0) ? cfg_extra_id : 24'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------

    task automatic wait_drained();
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both registers, the message id first, once nothing is in flight.
    task automatic write_config(input logic [23:0] msg_id, input logic [7:0] extra);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= cmfv_pkg::CFG_EXTRA_MSG_ID;
        cfg_data  <= msg_id;
        @(posedge clk);
        cfg_index <= cmfv_pkg::CFG_EXTRA_CRC;
        cfg_data  <= {16'h0000, extra};
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_extra_id   = msg_id;
        cfg_extra_byte = extra;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-off, checking
    // ------------------------------------------------------------------

    task automatic check_result();
        frame_flags_t got;
        frame_flags_t want;
        got = {result_ch.crsf_good, result_ch.crsf_frame_len, result_ch.mav_good,
               result_ch.mav_frame_len, result_ch.mav_version_two};
        if (expected_flags.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: result with no byte pending: crsf %0b/%0d mav %0b/%0d/%0b",
                         $realtime, got.crsf_good, got.crsf_frame_len, got.mav_good,
                         got.mav_frame_len, got.mav_version_two);
        end
        else
        begin
            want = expected_flags.pop_front();
            if (got.crsf_good !== want.crsf_good || got.crsf_frame_len !== want.crsf_frame_len
                || got.mav_good !== want.mav_good || got.mav_frame_len !== want.mav_frame_len
                || got.mav_version_two !== want.mav_version_two)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"%0t: expected crsf %0b/%0d mav %0b/%0d/%0b, ",
                              "got crsf %0b/%0d mav %0b/%0d/%0b"},
                             $realtime, want.crsf_good, want.crsf_frame_len, want.mav_good,
                             want.mav_frame_len, want.mav_version_two, got.crsf_good,
                             got.crsf_frame_len, got.mav_good, got.mav_frame_len,
                             got.mav_version_two);
            end
        end
    endtask

    // The receiver stalls at random, or holds off completely while hold_rx
    // is set; a request is taken at an edge where valid and ready are both high.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !hold_rx && ($urandom_range(0, 99) >= recv_stall_pct);
        if (rst_n && result_ch.valid && result_ch.ready)
            check_result();
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lengths one below the minimum and one above the maximum, a length byte
    // that is also a sync value (it must not restart the parser), then the
    // shortest good frame.
    task automatic test_crsf_length_bounds();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        frame_buf = '{cmfv_pkg::CRSF_SYNC_FC, 8'h01, cmfv_pkg::CRSF_SYNC_RX, 8'h3F,
                      cmfv_pkg::CRSF_SYNC_TX, cmfv_pkg::CRSF_SYNC_FC,
                      cmfv_pkg::CRSF_SYNC_FC, 8'h02, 8'hFF, crc8_step(8'h00, 8'hFF)};
        send_frame(frame_buf.size());
        stop_bytes();
    endtask

    // Empty v1 frame with the reset id, so the reset extra byte is folded in.
    task automatic test_mav_v1_frame();
        build_mav_frame(1'b0, 8'd0, cfg_extra_id, 1'b0);
        send_frame(frame_buf.size());
        stop_bytes();
    endtask

    // Empty v2 frame whose last CRC byte is a v2 start byte: the CRC fails and
    // that last byte must not open a new frame.
    task automatic test_mav_v2_bad_crc();
        build_mav_frame(1'b1, 8'd0, cfg_extra_id, 1'b0);
        if (frame_buf[frame_buf.size() - 1] == cmfv_pkg::MAV_STX_V2)
            frame_buf[frame_buf.size() - 2] = ~frame_buf[frame_buf.size() - 2];
        frame_buf[frame_buf.size() - 1] = cmfv_pkg::MAV_STX_V2;
        send_frame(frame_buf.size());
        stop_bytes();
    endtask

    // Mostly well-formed frames of both kinds with random content, plus
    // corrupted and cut-off frames and short bursts of noise.
    task automatic test_random_traffic(input int byte_budget, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int pick;
        int count;
        int len;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < byte_budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45 || (pick >= 80 && pick < 85))
            begin
                // Mostly short frames; now and then a long one, often the longest.
                if ($urandom_range(0, 9) != 0)
                    len = $urandom_range(cmfv_pkg::CRSF_MIN_LEN, 12);
                else if ($urandom_range(0, 2) == 0)
                    len = cmfv_pkg::CRSF_MAX_LEN;
                else
                    len = $urandom_range(13, cmfv_pkg::CRSF_MAX_LEN);
                build_crsf_frame(len, pick >= 80);
            end
            else if (pick < 90)
            begin
                if ($urandom_range(0, 19) != 0)
                    len = $urandom_range(0, 20);
                else if ($urandom_range(0, 1) == 0)
                    len = 255;
                else
                    len = $urandom_range(200, 255);
                build_mav_frame(1'($urandom_range(0, 1)), 8'(len), pick_msg_id(), pick >= 85);
            end
            else
            begin
                frame_buf.delete();
                repeat ($urandom_range(1, 5)) frame_buf.push_back(8'($urandom));
            end
            count = frame_buf.size();
            // Some broken frames are also cut short.
            if (pick >= 80 && pick < 90 && $urandom_range(0, 2) == 0)
                count = $urandom_range(1, frame_buf.size() - 1);
            send_frame(count);
            sent += count;
        end
        stop_bytes();
    endtask

    // The receiver holds off for a long stretch, counted in its own process,
    // while the sender keeps offering bytes, so the unit fills and stalls.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_rx <= 1'b0;
            end
        join_none
        repeat (5)
        begin
            build_crsf_frame($urandom_range(cmfv_pkg::CRSF_MIN_LEN, 6), 1'b0);
            send_frame(frame_buf.size());
        end
        build_mav_frame(1'b1, 8'($urandom_range(0, 8)), pick_msg_id(), 1'b0);
        send_frame(frame_buf.size());
        stop_bytes();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.in_byte = '0;
        result_ch.ready = 1'b0;
        hold_rx         = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        mismatch_count  = 0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases run with the reset configuration and no idling.
        test_crsf_length_bounds();
        test_mav_v1_frame();
        test_mav_v2_bad_crc();

        // Random traffic, each phase with its own configuration and idling.
        test_random_traffic(RANDOM_PHASE_BYTES, 0, 0);
        write_config(24'h000000, 8'h00);
        test_random_traffic(RANDOM_PHASE_BYTES, 46, 0);
        write_config(24'hFFFFFF, 8'hFF);
        test_random_traffic(RANDOM_PHASE_BYTES, 0, 46);
        // An id below 256 lets v1 frames pick up the extra byte as well.
        write_config(24'($urandom_range(0, 255)), 8'($urandom));
        test_random_traffic(RANDOM_PHASE_BYTES, 22, 22);
        test_backpressure();

        wait_drained();
        if (mismatch_count == 0 && expected_flags.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, far above the slowest correct run.
    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule
